[rtl/i2cm_pkg.sv]
// i2cm_pkg: shared types and constants of the i2c master bit sequencer
// no dependencies; imported by the front, back and top level modules

package i2cm_pkg;

    localparam int unsigned DELAY_W = 16;

    localparam logic [3:0]         BITS_PER_BYTE = 4'd8;
    localparam logic [DELAY_W-1:0] DELAY_RESET   = 16'd10;
    localparam int unsigned        MSB_BIT       = 7;
    localparam int unsigned        QUEUE_DEPTH   = 2;

    // command codes, same encoding as the mode field
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_READ  = 3'd4,
        OP_WAIT  = 3'd5,
        OP_ACK   = 3'd6,
        OP_NACK  = 3'd7
    } t_op;

    // one classified tick as queued between front and back
    typedef struct packed {
        t_op        op;
        logic [7:0] shift_init;
        logic       sda_in;
    } t_tick;

    // one result beat
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
        logic       rejected;
    } t_res;

    // queue status seen by the top level
    typedef struct packed {
        logic [1:0] level;
        logic       full;
    } t_q_stat;

endpackage

[rtl/i2cm_if.sv]
// i2cm channel interfaces: tick input, result output and delay config write
// no dependencies; used by the front, back and top level modules

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output mode, output tx_byte, output sda_in, input ready);
    modport sink   (input valid, input mode, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
    logic       rejected;

    modport source (
        output valid, output scl_level, output sda_level, output busy_res,
        output done_res, output rx_byte, output ack_missing, output rejected,
        input ready
    );
    modport sink (
        input valid, input scl_level, input sda_level, input busy_res,
        input done_res, input rx_byte, input ack_missing, input rejected,
        output ready
    );
endinterface

interface i2cm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] delay_ticks;

    modport source (output valid, output delay_ticks, input ready);
    modport sink   (input valid, input delay_ticks, output ready);
endinterface

[rtl/i2cm_front.sv]
// i2cm_front: accepts tick beats, classifies the command and queues them
// depends on i2cm_pkg and i2cm_in_if

module i2cm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cm_in_if.sink            i_item,
    output i2cm_pkg::t_tick    o_q_data,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output i2cm_pkg::t_q_stat  o_q_stat
);
    import i2cm_pkg::*;

    t_tick      r_mem [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_level;

    t_tick      w_tick;
    logic       w_push;
    logic       w_pop;

    // classify: only send byte keeps its data byte
    always_comb begin
        w_tick.op         = t_op'(i_item.mode);
        w_tick.shift_init = (t_op'(i_item.mode) == OP_SEND) ? i_item.tx_byte : 8'd0;
        w_tick.sda_in     = i_item.sda_in;
    end

    assign i_item.ready = (r_level != 2'(QUEUE_DEPTH));
    assign w_push       = i_item.valid && i_item.ready;
    assign o_q_valid    = (r_level != 2'd0);
    assign w_pop        = o_q_valid && i_q_ready;
    assign o_q_data     = r_mem[r_rp];

    assign o_q_stat.level = r_level;
    assign o_q_stat.full  = !i_item.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            priority if (w_push && !w_pop) begin
                r_level <= r_level + 2'd1;
            end else if (w_pop && !w_push) begin
                r_level <= r_level - 2'd1;
            end else begin
                r_level <= r_level;
            end
        end
    end

endmodule

[rtl/i2cm_back.sv]
// i2cm_back: runs the bus phase sequencer one tick per queued beat
// depends on i2cm_pkg, i2cm_out_if and i2cm_cfg_if

module i2cm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  i2cm_pkg::t_tick i_q_data,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    i2cm_cfg_if.sink        i_cfg,
    i2cm_out_if.source      o_res
);
    import i2cm_pkg::*;

    t_op                r_op;
    logic [1:0]         r_phase;
    logic [3:0]         r_bit;
    logic [7:0]         r_shift;
    logic [DELAY_W-1:0] r_cnt;
    logic               r_scl;
    logic               r_sda;
    logic [7:0]         r_rx;
    logic               r_ack;
    logic [DELAY_W-1:0] r_delay;
    logic               r_out_valid;
    t_res               r_res;

    t_op                n_op;
    logic [1:0]         n_phase;
    logic [3:0]         n_bit;
    logic [7:0]         n_shift;
    logic [DELAY_W-1:0] n_cnt;
    logic               n_scl;
    logic               n_sda;
    logic [7:0]         n_rx;
    logic               n_ack;
    logic               n_done;
    logic               n_rej;

    logic               w_fire;
    logic [DELAY_W-1:0] w_lim;
    logic [DELAY_W:0]   w_cnt_inc;

    function automatic logic [1:0] f_phases(input t_op op);
        logic [1:0] v;
        unique case (op)
            OP_STOP: v = 2'd1;
            OP_READ: v = 2'd2;
            default: v = 2'd3;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] f_bits(input t_op op);
        return (op == OP_SEND || op == OP_READ) ? BITS_PER_BYTE : 4'd1;
    endfunction

    // line levels on entry to a phase, returns {scl, sda}
    function automatic logic [1:0] f_enter(input t_op op, input logic [1:0] p,
                                           input logic [3:0] b, input logic [7:0] sh,
                                           input logic [1:0] lines);
        logic scl;
        logic sda;
        scl = lines[1];
        sda = lines[0];
        unique case (op)
            OP_START: begin
                if (p == 2'd0) begin
                    sda = 1'b1;
                    scl = 1'b1;
                end else if (p == 2'd1) begin
                    sda = 1'b0;
                end else begin
                    scl = 1'b0;
                end
            end
            OP_STOP: begin
                sda = 1'b0;
                scl = 1'b1;
            end
            OP_SEND: begin
                if (p == 2'd0) begin
                    sda = sh[MSB_BIT];
                end else if (p == 2'd1) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                    if (b == BITS_PER_BYTE - 4'd1) begin
                        sda = 1'b1;
                    end
                end
            end
            OP_READ: begin
                scl = (p == 2'd0);
            end
            OP_WAIT, OP_NACK: begin
                if (p == 2'd0) begin
                    sda = 1'b1;
                end else if (p == 2'd1) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
            OP_ACK: begin
                if (p == 2'd0) begin
                    sda = 1'b0;
                end else if (p == 2'd1) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
            OP_IDLE: begin
            end
        endcase
        return {scl, sda};
    endfunction

    // a beat is executed when the result register is free or drains this cycle
    assign o_q_ready = !r_out_valid || o_res.ready;
    assign w_fire    = i_q_valid && o_q_ready;
    assign w_lim     = (r_delay == '0) ? DELAY_W'(1) : r_delay;
    assign w_cnt_inc = {1'b0, r_cnt} + (DELAY_W+1)'(1);

    always_comb begin
        n_op    = r_op;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_ack   = r_ack;
        n_done  = 1'b0;
        n_rej   = 1'b0;
        if (w_fire) begin
            if (r_op != OP_IDLE) begin
                n_rej = (i_q_data.op != OP_IDLE);
                n_cnt = w_cnt_inc[DELAY_W-1:0];
                if (w_cnt_inc >= {1'b0, w_lim}) begin
                    if (r_op == OP_READ && r_phase == 2'd0) begin
                        n_shift = {r_shift[6:0], i_q_data.sda_in};
                    end
                    if (r_op == OP_WAIT && r_phase == 2'd1) begin
                        n_ack = i_q_data.sda_in;
                    end
                    n_cnt   = '0;
                    n_phase = r_phase + 2'd1;
                    if (n_phase >= f_phases(r_op)) begin
                        n_phase = 2'd0;
                        if (r_op == OP_SEND) begin
                            n_shift = {n_shift[6:0], 1'b0};
                        end
                        n_bit = r_bit + 4'd1;
                        if (n_bit >= f_bits(r_op)) begin
                            if (r_op == OP_STOP || r_op == OP_ACK) begin
                                n_sda = 1'b1;
                            end
                            if (r_op == OP_READ) begin
                                n_rx = n_shift;
                            end
                            n_op   = OP_IDLE;
                            n_bit  = 4'd0;
                            n_done = 1'b1;
                        end
                    end
                    if (!n_done) begin
                        {n_scl, n_sda} = f_enter(r_op, n_phase, n_bit, n_shift, {n_scl, n_sda});
                    end
                end
            end else if (i_q_data.op != OP_IDLE) begin
                n_op    = i_q_data.op;
                n_phase = 2'd0;
                n_bit   = 4'd0;
                n_cnt   = '0;
                n_shift = i_q_data.shift_init;
                {n_scl, n_sda} = f_enter(n_op, n_phase, n_bit, n_shift, {r_scl, r_sda});
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_IDLE;
            r_phase     <= 2'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_cnt       <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= 8'd0;
            r_ack       <= 1'b0;
            r_delay     <= DELAY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_op    <= n_op;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_rx    <= n_rx;
            r_ack   <= n_ack;
            if (i_cfg.valid) begin
                r_delay <= i_cfg.delay_ticks;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res.scl_level   <= n_scl;
            r_res.sda_level   <= n_sda;
            r_res.busy_res    <= (n_op != OP_IDLE);
            r_res.done_res    <= n_done;
            r_res.rx_byte     <= n_rx;
            r_res.ack_missing <= n_ack;
            r_res.rejected    <= n_rej;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.scl_level   = r_res.scl_level;
    assign o_res.sda_level   = r_res.sda_level;
    assign o_res.busy_res    = r_res.busy_res;
    assign o_res.done_res    = r_res.done_res;
    assign o_res.rx_byte     = r_res.rx_byte;
    assign o_res.ack_missing = r_res.ack_missing;
    assign o_res.rejected    = r_res.rejected;

endmodule

[rtl/i2c_master_bit_sequencer.sv]
// i2c_master_bit_sequencer: top level of the open-drain i2c master sequencer
// depends on i2cm_pkg, i2cm_if, i2cm_front and i2cm_back

// every input beat is one bus timing tick, optionally carrying a command
// (start, stop, send byte, read byte, wait ack, ack, nack) plus the sampled
// data line; every beat yields exactly one result beat with the line drives,
// busy, a done pulse, the last received byte, the ack flag and a rejected flag
// for a command given while a sequence runs. each bus phase lasts delay_ticks
// ticks (0 acts as 1), written through the config channel; the user is to
// write it only while idle, which the block does not enforce. its reset
// value is 10. throughput is one beat per clock while results drain: the
// front queues classified beats in a two-entry queue, the back executes one
// tick per clock while the result register is free or drains; a beat passes
// the queue, then the result register. the state is one register set.

module i2c_master_bit_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_in_if.sink     i_item,
    i2cm_out_if.source  o_res,
    i2cm_cfg_if.sink    i_cfg
);
    import i2cm_pkg::*;

    // classified ticks between front and back
    t_tick   w_q_data;
    logic    w_q_valid;
    logic    w_q_ready;
    t_q_stat w_q_stat;

    // front: beat acceptance, command decode, tick queue
    i2cm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_q_data (w_q_data),
        .o_q_valid(w_q_valid),
        .i_q_ready(w_q_ready),
        .o_q_stat (w_q_stat)
    );

    // back: phase sequencer, delay register, result register
    i2cm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (w_q_data),
        .i_q_valid(w_q_valid),
        .o_q_ready(w_q_ready),
        .i_cfg    (i_cfg),
        .o_res    (o_res)
    );

`ifndef ASSERT_OFF
    // queue never holds more than its depth, full flag tracks the level
    a_q_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.level <= 2'(QUEUE_DEPTH) &&
        w_q_stat.full == (w_q_stat.level == 2'(QUEUE_DEPTH)))
        else $error("tick queue over depth");

    // a finished sequence is not reported busy
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.done_res |-> !o_res.busy_res)
        else $error("done with busy set");

    // a rejection only happens during a sequence or on its last tick
    a_rej_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.rejected |-> o_res.busy_res || o_res.done_res)
        else $error("rejected while idle");

    // a queued beat reaches the back at the latest once the result drains
    a_q_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && o_res.ready |-> w_q_ready)
        else $error("back stalled with free result register");
`endif

endmodule
